>>> rtl/amaq_pkg.sv
package amaq_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int QUAT_BITS   = 16;

  // pipeline depths
  localparam int NORM_STEPS = 6;               // binary search over a 6-bit shift amount
  localparam int SQRT_STEPS = 32;              // one root bit per stage
  localparam int SQRT_LAT   = SQRT_STEPS + 1;
  localparam int DIV_STEPS  = 31;              // quotient bits 30..0
  localparam int UNIT_LAT   = NORM_STEPS + SQRT_LAT + DIV_STEPS + 7;
  localparam int TOP_LAT    = 2 * UNIT_LAT + SQRT_LAT + 7;

  localparam logic [63:0] ONE_Q30 = 64'd1 << 30;
  localparam int Q_SH = (QUAT_BITS < 31) ? 31 - QUAT_BITS : 1;

  typedef logic [3:0][63:0] lane4_t;
  typedef logic [3:0][31:0] unit4_t;

  // Q30 to QUAT_BITS-1 fractional bits: round half up, saturate
  function automatic logic [QUAT_BITS-1:0] to_q(input logic signed [31:0] u);
    logic signed [63:0] r;
    logic signed [63:0] hi;
    logic signed [63:0] lo;
    hi = (64'sd1 <<< (QUAT_BITS - 1)) - 64'sd1;
    lo = -(64'sd1 <<< (QUAT_BITS - 1));
    if (QUAT_BITS - 1 < 30) begin
      r = (64'(u) + (64'sd1 <<< (Q_SH - 1))) >>> Q_SH;
    end else if (QUAT_BITS - 1 == 30) begin
      r = 64'(u);
    end else begin
      r = 64'(u) <<< 1;
    end
    if (r > hi) r = hi;
    if (r < lo) r = lo;
    return r[QUAT_BITS-1:0];
  endfunction

endpackage

>>> rtl/amaq_sqrt.sv
module amaq_sqrt import amaq_pkg::*; (
  input  logic        clk,
  input  logic        en,
  input  logic [63:0] rad,
  output logic [31:0] root
);

  logic [63:0] rem_r [SQRT_STEPS+1];
  logic [63:0] res_r [SQRT_STEPS+1];

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= rad;
      res_r[0] <= '0;
    end
  end

  for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_step
    localparam int BPOS = 2 * (SQRT_STEPS - 1 - j);
    logic [64:0] trial;
    assign trial = {1'b0, res_r[j]} + (65'd1 << BPOS);
    always_ff @(posedge clk) begin
      if (en) begin
        if ({1'b0, rem_r[j]} >= trial) begin
          rem_r[j+1] <= rem_r[j] - trial[63:0];
          res_r[j+1] <= (res_r[j] >> 1) + (64'd1 << BPOS);
        end else begin
          rem_r[j+1] <= rem_r[j];
          res_r[j+1] <= res_r[j] >> 1;
        end
      end
    end
  end

  assign root = res_r[SQRT_STEPS][31:0];

endmodule

>>> rtl/amaq_unitize.sv
module amaq_unitize import amaq_pkg::*; (
  input  logic   clk,
  input  logic   en,
  input  lane4_t vin,
  output unit4_t uout,
  output logic   zero
);

  typedef struct packed {
    lane4_t val;
    lane4_t mag;
    logic   big;
    logic   zero;
  } nst_t;

  typedef struct packed {
    unit4_t     aw;
    logic [3:0] sg;
    logic       zero;
  } side_t;

  typedef struct packed {
    lane4_t           rem;
    logic [3:0][30:0] qt;
    logic [31:0]      dsr;
    logic [3:0]       sg;
    logic             zero;
  } dst_t;

  nst_t   nst_r [NORM_STEPS+1];
  nst_t   nst_nxt;
  side_t  abs_r, abs_nxt, sq_side_r, sa_side_r, sb_side_r;
  side_t  sd_r [SQRT_LAT];
  lane4_t sq_r;
  logic [63:0] s01_r, s23_r, sum_r;
  logic [31:0] nrm;
  dst_t   dv_r [DIV_STEPS+1];
  dst_t   dv_nxt;
  unit4_t uout_r, uout_nxt;
  logic   zero_r;

  // magnitudes, big = needs right shift, zero = all lanes zero
  always_comb begin
    nst_nxt      = '0;
    nst_nxt.val  = vin;
    nst_nxt.zero = 1'b1;
    for (int i = 0; i < 4; i++) begin
      nst_nxt.mag[i] = vin[i][63] ? (~vin[i] + 64'd1) : vin[i];
      if (nst_nxt.mag[i] > ONE_Q30) nst_nxt.big = 1'b1;
      if (nst_nxt.mag[i] != '0) nst_nxt.zero = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) nst_r[0] <= nst_nxt;
  end

  // minimal shift found MSB first: largest magnitude into [2^29, 2^30]
  for (genvar n = 0; n < NORM_STEPS; n++) begin : g_norm
    localparam int SH = 1 << (NORM_STEPS - 1 - n);
    localparam int TS = SH - 1;
    logic ok_rt, ok_lt;
    nst_t st;
    always_comb begin
      ok_rt = 1'b1;
      ok_lt = 1'b0;
      st    = nst_r[n];
      for (int i = 0; i < 4; i++) begin
        if ((nst_r[n].mag[i] >> TS) > ONE_Q30) ok_rt = 1'b0;
        if ((nst_r[n].mag[i] << TS) >= (ONE_Q30 >> 1)) ok_lt = 1'b1;
      end
      if (nst_r[n].big && !ok_rt) begin
        for (int i = 0; i < 4; i++) begin
          st.mag[i] = nst_r[n].mag[i] >> SH;
          st.val[i] = $signed(nst_r[n].val[i]) >>> SH;
        end
      end else if (!nst_r[n].big && !ok_lt) begin
        for (int i = 0; i < 4; i++) begin
          st.mag[i] = nst_r[n].mag[i] << SH;
          st.val[i] = nst_r[n].val[i] << SH;
        end
      end
    end
    always_ff @(posedge clk) begin
      if (en) nst_r[n+1] <= st;
    end
  end

  always_comb begin
    logic [63:0] v;
    logic [63:0] a;
    abs_nxt      = '0;
    abs_nxt.zero = nst_r[NORM_STEPS].zero;
    for (int i = 0; i < 4; i++) begin
      v = nst_r[NORM_STEPS].val[i];
      a = v[63] ? (~v + 64'd1) : v;
      abs_nxt.aw[i] = a[31:0];
      abs_nxt.sg[i] = v[63];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      abs_r <= abs_nxt;
      for (int i = 0; i < 4; i++) begin
        sq_r[i] <= abs_r.aw[i] * abs_r.aw[i];
      end
      sq_side_r <= abs_r;
      s01_r     <= sq_r[0] + sq_r[1];
      s23_r     <= sq_r[2] + sq_r[3];
      sa_side_r <= sq_side_r;
      sum_r     <= s01_r + s23_r;
      sb_side_r <= sa_side_r;
      sd_r[0]   <= sb_side_r;
      for (int j = 1; j < SQRT_LAT; j++) begin
        sd_r[j] <= sd_r[j-1];
      end
    end
  end

  amaq_sqrt u_sqrt (
    .clk  (clk),
    .en   (en),
    .rad  (sum_r),
    .root (nrm)
  );

  // dividend with half the divisor added for round half away from zero
  always_comb begin
    dv_nxt      = '0;
    dv_nxt.dsr  = nrm;
    dv_nxt.sg   = sd_r[SQRT_LAT-1].sg;
    dv_nxt.zero = sd_r[SQRT_LAT-1].zero;
    for (int i = 0; i < 4; i++) begin
      dv_nxt.rem[i] = ({32'd0, sd_r[SQRT_LAT-1].aw[i]} << 30) + {33'd0, nrm[31:1]};
    end
  end

  always_ff @(posedge clk) begin
    if (en) dv_r[0] <= dv_nxt;
  end

  for (genvar d = 0; d < DIV_STEPS; d++) begin : g_div
    localparam int K = DIV_STEPS - 1 - d;
    logic [63:0] dk;
    dst_t st;
    assign dk = {32'd0, dv_r[d].dsr} << K;
    always_comb begin
      st = dv_r[d];
      for (int i = 0; i < 4; i++) begin
        if (dv_r[d].rem[i] >= dk) begin
          st.rem[i]   = dv_r[d].rem[i] - dk;
          st.qt[i][K] = 1'b1;
        end
      end
    end
    always_ff @(posedge clk) begin
      if (en) dv_r[d+1] <= st;
    end
  end

  always_comb begin
    logic [30:0] q;
    for (int i = 0; i < 4; i++) begin
      q = dv_r[DIV_STEPS].qt[i];
      if ({33'd0, q} > ONE_Q30) q = ONE_Q30[30:0];
      uout_nxt[i] = dv_r[DIV_STEPS].sg[i] ? (~{1'b0, q} + 32'd1) : {1'b0, q};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      uout_r <= uout_nxt;
      zero_r <= dv_r[DIV_STEPS].zero;
    end
  end

  assign uout = uout_r;
  assign zero = zero_r;

endmodule

>>> rtl/accel_mag_attitude_quaternion_core.sv
// Attitude quaternion from one accelerometer and one magnetometer sample.
// Input transfer: in_valid high and in_stall low at a rising edge of clk; the six
// signed samples travel together. Result transfer: out_valid high and out_stall
// low; the four Q1.15 components and out_bad_input travel together.
// out_bad_input is set, and the quaternion is zero, when either input vector
// or the resulting quaternion is all zero.
// The pipeline takes a new item every cycle while in_stall is low; the depth
// comes from two vector normalizers in series (6-step shift search, 32-stage
// square root, 31-stage divider each) and the 32-stage square root that forms
// bx.
// A result refused by out_stall moves into a one-entry skid register; from the
// next cycle in_stall is high and every stage holds until that register has
// been taken. in_stall is a register output. Nothing is dropped or repeated.
// rst_n is synchronous, active low, and clears all valid bits; results in
// flight are discarded.
module accel_mag_attitude_quaternion_core import amaq_pkg::*; (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [SAMPLE_BITS-1:0] in_accel_x,
  input  logic signed [SAMPLE_BITS-1:0] in_accel_y,
  input  logic signed [SAMPLE_BITS-1:0] in_accel_z,
  input  logic signed [SAMPLE_BITS-1:0] in_mag_x,
  input  logic signed [SAMPLE_BITS-1:0] in_mag_y,
  input  logic signed [SAMPLE_BITS-1:0] in_mag_z,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [QUAT_BITS-1:0]   out_quat_w,
  output logic signed [QUAT_BITS-1:0]   out_quat_x,
  output logic signed [QUAT_BITS-1:0]   out_quat_y,
  output logic signed [QUAT_BITS-1:0]   out_quat_z,
  output logic                          out_bad_input
);

  typedef struct packed {
    logic signed [31:0] ua0;
    logic signed [31:0] ua1;
    logic signed [31:0] ua2;
    logic signed [31:0] um0;
    logic signed [31:0] um1;
    logic signed [31:0] um2;
    logic signed [31:0] bz;
    logic               bad;
  } cry_t;

  logic en;
  logic [TOP_LAT-1:0] vld_r;
  lane4_t acc_v, mag_v, q_v;
  unit4_t ua, um, uq;
  logic   za, zm, zq;

  cry_t t1_r, t2_r, t3_r, c5, t2_nxt;
  cry_t sd_r [SQRT_LAT];
  logic signed [63:0] p_r [3];
  logic signed [63:0] dot_nxt;
  logic signed [33:0] bzw_nxt;
  logic signed [31:0] bz_nxt;
  logic [63:0] bz2_r;
  logic [31:0] bx;

  logic signed [32:0] bxmx_r, azm1_r, bzmz_r;
  logic signed [31:0] ua0_r, ua1_r, ua2_r, um1_r, um2_r, bz5_r, bx_r, um2_6r;
  logic bad5_r, bad6_r, bad7_r;
  logic signed [63:0] m_r [8];
  logic signed [63:0] q_r [4];
  logic [UNIT_LAT-1:0] bd_r;

  logic signed [QUAT_BITS-1:0] pw_r, px_r, py_r, pz_r;
  logic signed [QUAT_BITS-1:0] skw_r, skx_r, sky_r, skz_r;
  logic pbad_r, skbad_r, sk_vld_r;

  assign en       = !sk_vld_r;
  assign in_stall = sk_vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[TOP_LAT-2:0], in_valid};
    end
  end

  assign acc_v[0] = 64'(in_accel_x);
  assign acc_v[1] = 64'(in_accel_y);
  assign acc_v[2] = 64'(in_accel_z);
  assign acc_v[3] = '0;
  assign mag_v[0] = 64'(in_mag_x);
  assign mag_v[1] = 64'(in_mag_y);
  assign mag_v[2] = 64'(in_mag_z);
  assign mag_v[3] = '0;

  amaq_unitize u_acc (.clk(clk), .en(en), .vin(acc_v), .uout(ua), .zero(za));
  amaq_unitize u_mag (.clk(clk), .en(en), .vin(mag_v), .uout(um), .zero(zm));

  // bz = round(ua . um), clamped to +-1
  assign dot_nxt = p_r[0] + p_r[1] + p_r[2] + 64'sd536870912;
  assign bzw_nxt = dot_nxt[63:30];
  always_comb begin
    if (bzw_nxt > 34'sd1073741824) begin
      bz_nxt = 32'sd1073741824;
    end else if (bzw_nxt < -34'sd1073741824) begin
      bz_nxt = -32'sd1073741824;
    end else begin
      bz_nxt = bzw_nxt[31:0];
    end
  end

  always_comb begin
    t2_nxt    = t1_r;
    t2_nxt.bz = bz_nxt;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_r[0]   <= $signed(ua[0]) * $signed(um[0]);
      p_r[1]   <= $signed(ua[1]) * $signed(um[1]);
      p_r[2]   <= $signed(ua[2]) * $signed(um[2]);
      t1_r     <= '{ua0: ua[0], ua1: ua[1], ua2: ua[2], um0: um[0], um1: um[1],
                    um2: um[2], bz: '0, bad: za || zm};
      t2_r     <= t2_nxt;
      bz2_r    <= t2_r.bz * t2_r.bz;
      t3_r     <= t2_r;
      sd_r[0]  <= t3_r;
      for (int j = 1; j < SQRT_LAT; j++) begin
        sd_r[j] <= sd_r[j-1];
      end
    end
  end

  amaq_sqrt u_bx (
    .clk  (clk),
    .en   (en),
    .rad  ((64'd1 << 60) - bz2_r),
    .root (bx)
  );

  assign c5 = sd_r[SQRT_LAT-1];

  always_ff @(posedge clk) begin
    if (en) begin
      bxmx_r <= $signed({1'b0, bx}) + 33'(c5.um0);
      azm1_r <= 33'(c5.ua2) - 33'sd1073741824;
      bzmz_r <= 33'(c5.bz) - 33'(c5.um2);
      ua0_r  <= c5.ua0;
      ua1_r  <= c5.ua1;
      ua2_r  <= c5.ua2;
      um1_r  <= c5.um1;
      um2_r  <= c5.um2;
      bz5_r  <= c5.bz;
      bx_r   <= $signed(bx);
      bad5_r <= c5.bad;

      m_r[0] <= ua1_r * bxmx_r;
      m_r[1] <= ua0_r * um1_r;
      m_r[2] <= azm1_r * bxmx_r;
      m_r[3] <= ua0_r * bzmz_r;
      m_r[4] <= azm1_r * um1_r;
      m_r[5] <= ua1_r * bzmz_r;
      m_r[6] <= ua2_r * bz5_r;
      m_r[7] <= ua0_r * bx_r;
      um2_6r <= um2_r;
      bad6_r <= bad5_r;

      q_r[0] <= m_r[1] - m_r[0];
      q_r[1] <= m_r[2] + m_r[3];
      q_r[2] <= m_r[4] + m_r[5];
      q_r[3] <= m_r[6] - m_r[7] - (64'(um2_6r) <<< 30);
      bad7_r <= bad6_r;

      bd_r   <= {bd_r[UNIT_LAT-2:0], bad7_r};
    end
  end

  assign q_v[0] = q_r[0];
  assign q_v[1] = q_r[1];
  assign q_v[2] = q_r[2];
  assign q_v[3] = q_r[3];

  amaq_unitize u_quat (.clk(clk), .en(en), .vin(q_v), .uout(uq), .zero(zq));

  logic bad_nxt;
  assign bad_nxt = bd_r[UNIT_LAT-1] || zq;

  always_ff @(posedge clk) begin
    if (en) begin
      pbad_r <= bad_nxt;
      pw_r   <= bad_nxt ? '0 : to_q($signed(uq[0]));
      px_r   <= bad_nxt ? '0 : to_q($signed(uq[1]));
      py_r   <= bad_nxt ? '0 : to_q($signed(uq[2]));
      pz_r   <= bad_nxt ? '0 : to_q($signed(uq[3]));
    end
  end

  // skid entry holds the older result while the pipeline is frozen
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sk_vld_r <= 1'b0;
    end else if (sk_vld_r) begin
      if (!out_stall) sk_vld_r <= 1'b0;
    end else if (vld_r[TOP_LAT-1] && out_stall) begin
      sk_vld_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!sk_vld_r) begin
      skw_r   <= pw_r;
      skx_r   <= px_r;
      sky_r   <= py_r;
      skz_r   <= pz_r;
      skbad_r <= pbad_r;
    end
  end

  assign out_valid     = sk_vld_r || vld_r[TOP_LAT-1];
  assign out_quat_w    = sk_vld_r ? skw_r : pw_r;
  assign out_quat_x    = sk_vld_r ? skx_r : px_r;
  assign out_quat_y    = sk_vld_r ? sky_r : py_r;
  assign out_quat_z    = sk_vld_r ? skz_r : pz_r;
  assign out_bad_input = sk_vld_r ? skbad_r : pbad_r;

  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_bad_input |->
      out_quat_w == '0 && out_quat_x == '0 && out_quat_y == '0 && out_quat_z == '0)
    else $error("flagged result carries a nonzero quaternion");

  a_good_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_bad_input |->
      out_quat_w != '0 || out_quat_x != '0 || out_quat_y != '0 || out_quat_z != '0)
    else $error("unflagged result has zero quaternion");

  a_accept_tracked: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> vld_r[0])
    else $error("accepted item lost its valid bit");

endmodule

>>> tb/sv/tb_top.sv
module tb_top;
  import amaq_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LAT = 194;
  localparam int WDOG_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [SAMPLE_BITS-1:0] in_accel_x = '0, in_accel_y = '0, in_accel_z = '0;
  logic signed [SAMPLE_BITS-1:0] in_mag_x = '0, in_mag_y = '0, in_mag_z = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [QUAT_BITS-1:0] out_quat_w, out_quat_x, out_quat_y, out_quat_z;
  logic out_bad_input;

  typedef struct {
    logic signed [QUAT_BITS-1:0] w, x, y, z;
    logic bad;
  } attitude_t;

  typedef struct {
    logic signed [15:0] ax, ay, az, mx, my, mz;
    bit known;
    logic signed [15:0] w, x, y, z;
    logic bad;
  } vec_row_t;

  attitude_t attitude_q[$];
  int errors = 0;
  int in_idle_pct = 26;
  int out_idle_pct = 56;
  bit hold_out = 1'b0;
  int idle_cycles = 0;

  always #6 clk = ~clk;

  accel_mag_attitude_quaternion_core i_dut (.*);

  // ---------------- predictor ----------------
  function automatic logic [63:0] isqrt(input logic [63:0] s);
    logic [63:0] res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > s) b >>= 2;
    while (b != 0) begin
      if (s >= res + b) begin
        s -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic longint floor_shr(input longint v, input int k);
    return v >>> k;
  endfunction

  function automatic logic [63:0] absval(input longint v);
    return v < 0 ? 64'(-v) : 64'(v);
  endfunction

  // scale n components to unit length in Q30
  function automatic bit unit_vec(input longint v[4], input int n, output longint u[4]);
    longint w[4];
    logic [63:0] mx, sum, nrm, m, q;
    int s;
    mx = 0; sum = 0; s = 0;
    for (int i = 0; i < 4; i++) begin
      u[i] = 0;
      w[i] = 0;
    end
    for (int i = 0; i < n; i++) if (absval(v[i]) > mx) mx = absval(v[i]);
    if (mx == 0) return 1'b0;
    if (mx > ONE_Q30) begin
      while ((mx >> s) > ONE_Q30) s++;
      for (int i = 0; i < n; i++) w[i] = floor_shr(v[i], s);
    end else begin
      while ((mx << s) < (64'd1 << 29)) s++;
      for (int i = 0; i < n; i++) w[i] = v[i] <<< s;
    end
    for (int i = 0; i < n; i++) begin
      m = absval(w[i]);
      sum += m * m;
    end
    nrm = isqrt(sum);
    for (int i = 0; i < n; i++) begin
      m = absval(w[i]);
      q = ((m << 30) + nrm / 2) / nrm;
      if (q > ONE_Q30) q = ONE_Q30;
      u[i] = w[i] < 0 ? -longint'(q) : longint'(q);
    end
    return 1'b1;
  endfunction

  function automatic logic signed [QUAT_BITS-1:0] q30_to_out(input longint u);
    longint r, hi, lo;
    hi = (longint'(1) << (QUAT_BITS - 1)) - 1;
    lo = -(longint'(1) << (QUAT_BITS - 1));
    r = (u + (longint'(1) << (30 - QUAT_BITS))) >>> (31 - QUAT_BITS);
    if (r > hi) r = hi;
    if (r < lo) r = lo;
    return r[QUAT_BITS-1:0];
  endfunction

  function automatic attitude_t predict_attitude(input vec_row_t r);
    longint a[4], m[4], ua[4], um[4], q[4], uq[4];
    longint one, bz, bx, bxmx, azm1, bzmz;
    bit ok;
    attitude_t res;
    one = longint'(ONE_Q30);
    a = '{longint'(r.ax), longint'(r.ay), longint'(r.az), 0};
    m = '{longint'(r.mx), longint'(r.my), longint'(r.mz), 0};
    ok = unit_vec(a, 3, ua);
    ok = unit_vec(m, 3, um) && ok;
    if (ok) begin
      bz = ua[0] * um[0] + ua[1] * um[1] + ua[2] * um[2];
      bz = (bz + (longint'(1) << 29)) >>> 30;
      if (bz > one) bz = one;
      if (bz < -one) bz = -one;
      bx = longint'(isqrt(64'(one * one - bz * bz)));
      bxmx = bx + um[0];
      azm1 = ua[2] - one;
      bzmz = bz - um[2];
      q[0] = -ua[1] * bxmx + ua[0] * um[1];
      q[1] = azm1 * bxmx + ua[0] * bzmz;
      q[2] = azm1 * um[1] + ua[1] * bzmz;
      q[3] = ua[2] * bz - ua[0] * bx - um[2] * one;
      ok = unit_vec(q, 4, uq);
    end
    res.w = ok ? q30_to_out(uq[0]) : '0;
    res.x = ok ? q30_to_out(uq[1]) : '0;
    res.y = ok ? q30_to_out(uq[2]) : '0;
    res.z = ok ? q30_to_out(uq[3]) : '0;
    res.bad = !ok;
    return res;
  endfunction

  // ---------------- checking ----------------
  task automatic report_mismatch(input string what, input longint got, input longint exp_v);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, exp_v, $realtime);
    errors++;
  endtask

  always @(posedge clk) begin
    attitude_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (attitude_q.size() == 0) begin
        report_mismatch("unexpected transfer", 0, 0);
      end else begin
        e = attitude_q.pop_front();
        if (out_quat_w !== e.w) report_mismatch("quat_w", out_quat_w, e.w);
        if (out_quat_x !== e.x) report_mismatch("quat_x", out_quat_x, e.x);
        if (out_quat_y !== e.y) report_mismatch("quat_y", out_quat_y, e.y);
        if (out_quat_z !== e.z) report_mismatch("quat_z", out_quat_z, e.z);
        if (out_bad_input !== e.bad) report_mismatch("bad_input", out_bad_input, e.bad);
      end
    end
  end

  // receiver stall
  always @(posedge clk) begin
    out_stall <= hold_out || ($urandom_range(99) < out_idle_pct);
  end

  // watchdog: cycles with no transfer on either side
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WDOG_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // ---------------- stimulus ----------------
  task automatic send_vec(input vec_row_t r);
    attitude_t e;
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    {in_accel_x, in_accel_y, in_accel_z} <= {r.ax, r.ay, r.az};
    {in_mag_x, in_mag_y, in_mag_z} <= {r.mx, r.my, r.mz};
    e = predict_attitude(r);
    if (r.known) begin
      e.w = r.w; e.x = r.x; e.y = r.y; e.z = r.z; e.bad = r.bad;
    end
    attitude_q.push_back(e);
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (attitude_q.size() != 0) @(posedge clk);
  endtask

  function automatic vec_row_t rand_vec();
    vec_row_t r;
    int sh;
    r.known = 0;
    // mix of full-scale and small magnitudes, both signs
    sh = $urandom_range(15);
    r.ax = $signed(16'($urandom)) >>> sh;
    r.ay = $signed(16'($urandom)) >>> sh;
    r.az = $signed(16'($urandom)) >>> sh;
    sh = $urandom_range(15);
    r.mx = $signed(16'($urandom)) >>> sh;
    r.my = $signed(16'($urandom)) >>> sh;
    r.mz = $signed(16'($urandom)) >>> sh;
    case ($urandom_range(19))
      0: {r.ax, r.ay, r.az} = '0;
      1: {r.mx, r.my, r.mz} = '0;
      2: {r.mx, r.my, r.mz} = {r.ax, r.ay, r.az};
      3: {r.mx, r.my, r.mz} = {-r.ax, -r.ay, -r.az};
      4: begin r.ax = 0; r.ay = 0; end
      default: ;
    endcase
    r.w = 0; r.x = 0; r.y = 0; r.z = 0; r.bad = 0;
    return r;
  endfunction

  vec_row_t vec_table[$];

  initial begin
    vec_row_t r;
    // zero-norm inputs, errors typed in
    vec_table.push_back('{0, 0, 0, 100, 0, 0, 1, 0, 0, 0, 0, 1});
    vec_table.push_back('{0, 0, 100, 0, 0, 0, 1, 0, 0, 0, 0, 1});
    vec_table.push_back('{0, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0, 1});
    // extremes and axis cases
    vec_table.push_back('{-32768, -32768, -32768, -32768, -32768, -32768, 0, 0, 0, 0, 0, 0});
    vec_table.push_back('{32767, 32767, 32767, 32767, 32767, 32767, 0, 0, 0, 0, 0, 0});
    vec_table.push_back('{-32768, 0, 0, 0, 32767, 0, 0, 0, 0, 0, 0, 0});
    vec_table.push_back('{0, 0, 1, 1, 0, 0, 0, 0, 0, 0, 0, 0});
    vec_table.push_back('{0, 0, -1, 1, 0, 0, 0, 0, 0, 0, 0, 0});
    vec_table.push_back('{0, 0, 1, 0, 0, 1, 0, 0, 0, 0, 0, 0});
    vec_table.push_back('{0, 0, 1, 0, 0, -1, 0, 0, 0, 0, 0, 0});
    vec_table.push_back('{1, 0, 0, -1, 0, 0, 0, 0, 0, 0, 0, 0});
    vec_table.push_back('{0, 1, 0, 0, -32768, 0, 0, 0, 0, 0, 0, 0});
    vec_table.push_back('{1, -1, 1, -1, 1, -1, 0, 0, 0, 0, 0, 0});
    vec_table.push_back('{-21846, 21845, -1, 16384, -16384, 8192, 0, 0, 0, 0, 0, 0});
    vec_table.push_back('{0, 0, 32767, 32767, 0, 0, 0, 0, 0, 0, 0, 0});
    vec_table.push_back('{0, 0, -32768, -32768, 0, 0, 0, 0, 0, 0, 0, 0});

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (vec_table[i]) send_vec(vec_table[i]);

    for (int ph = 0; ph < 3; ph++) begin
      if (ph == 1) begin in_idle_pct = 56; out_idle_pct = 26; end
      if (ph == 2) begin in_idle_pct = 0; out_idle_pct = 0; end
      for (int n = 0; n < 500; n++) begin
        if (ph == 0 && n == 100) begin
          // long receiver hold-off while inputs keep coming
          fork
            begin
              hold_out = 1'b1;
              repeat (600) @(posedge clk);
              hold_out = 1'b0;
            end
          join_none
        end
        if (n == 250) drain();
        r = rand_vec();
        send_vec(r);
      end
    end
    drain();
    repeat (LAT + 20) @(posedge clk);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule

>>> accel_mag_attitude_quaternion_core.f
rtl/amaq_pkg.sv
rtl/amaq_sqrt.sv
rtl/amaq_unitize.sv
rtl/accel_mag_attitude_quaternion_core.sv
tb/sv/tb_top.sv
